// ----- design/bcs_pkg.sv -----
`timescale 1ns / 1ps
package bcs_pkg;

  // one control point, coordinates in signed fixed point
  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pt_t;

  typedef pt_t [3:0] crv_t;

  typedef enum logic [1:0] {
    MODE_SPLIT,
    MODE_LEFT,
    MODE_RIGHT,
    MODE_MID
  } mode_t;

  // what travels beside the curve through a cut pipeline
  typedef struct packed {
    mode_t mode;
    crv_t  ea;
    crv_t  eb;
  } side_t;

  localparam logic [1:0] HALF_LEFT  = 2'd0;
  localparam logic [1:0] HALF_RIGHT = 2'd1;
  localparam logic [1:0] HALF_SEG   = 2'd2;

  localparam logic signed [17:0] T_ONE = 18'sd65536;
  localparam int PROD_W = 51;
  localparam int DIV_W  = 19;
  localparam int Q_W    = 16;

  // (b - a) * t, exact
  function automatic logic signed [PROD_W-1:0] lmul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input logic signed [17:0] t);
    logic signed [32:0] d;
    d = {b[31], b} - {a[31], a};
    lmul = d * t;
  endfunction

  // a + floor((p + 2^15) / 2^16), saturated to 32 bits
  function automatic logic signed [31:0] lerp_fin(input logic signed [31:0] a,
                                                  input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] pr;
    logic [35:0]       s;
    pr = p + PROD_W'(32768);
    s  = {{4{a[31]}}, a} + {pr[PROD_W-1], pr[PROD_W-1:16]};
    if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111) begin
      lerp_fin = s[31:0];
    end else if (s[35]) begin
      lerp_fin = {1'b1, 31'b0};
    end else begin
      lerp_fin = {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

// ----- design/bezier_curve_split.sv -----
`timescale 1ns / 1ps
// path: an accepted item passes the input register, both cuts and the serializer before its first point is valid
// throughput: one item enters per cycle while the output stage is free; points leave one per
//   cycle while out_tready is high, and an item gives 3 to 8 points (sent by the output serializer)
// reset: rst_n synchronous active low, clears the valid bits of every stage and the serializer
module bezier_curve_split (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // degree[1:0], px0, py0, px1, py1, px2, py2, px3, py3, t_start[17:0], t_end[17:0], zero pad
  input  logic [295:0] in_tdata,
  // opcode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_index[1:0], out_x[31:0], out_y[31:0], zero pad
  output logic [71:0]  out_tdata,
  // half
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  // whole pipeline moves on one enable, held whenever the serializer is still busy
  logic en;
  logic ser_free;

  // stage 0: accepted item
  logic               s0_v_r;
  logic               opc_r, cubic_r;
  bcs_pkg::crv_t      crv_r;
  logic signed [17:0] ts_r, te_r;

  assign en        = ser_free;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opc_r   <= in_tuser[0];
      cubic_r <= in_tdata[1:0] == 2'd3;
      for (int i = 0; i < 4; i++) begin
        crv_r[i].x <= in_tdata[2 + 64*i +: 32];
        crv_r[i].y <= in_tdata[34 + 64*i +: 32];
      end
      ts_r <= in_tdata[258 +: 18];
      te_r <= in_tdata[276 +: 18];
    end
  end

  // decide the case and the parameter of the first cut
  bcs_pkg::mode_t      mode;
  logic signed [17:0]  t1;
  logic signed [18:0]  num, den;
  logic [18:0]         an, ad;
  logic                dzero, dsat;
  bcs_pkg::side_t      side1;

  always_comb begin
    if (!opc_r) begin
      mode = bcs_pkg::MODE_SPLIT;
    end else if (ts_r <= 18'sd0) begin
      mode = bcs_pkg::MODE_LEFT;
    end else if (te_r >= bcs_pkg::T_ONE) begin
      mode = bcs_pkg::MODE_RIGHT;
    end else begin
      mode = bcs_pkg::MODE_MID;
    end
    t1    = (mode == bcs_pkg::MODE_LEFT) ? te_r : ts_r;
    // remap (t_end - t_start) / (1 - t_start) on magnitudes
    num   = te_r - ts_r;
    den   = 19'sd65536 - ts_r;
    dzero = den == '0 || num == '0 || num[18] != den[18];
    an    = num[18] ? 19'(-num) : num;
    ad    = den[18] ? 19'(-den) : den;
    dsat  = an >= ad;
    side1 = '{mode: mode, ea: '0, eb: '0};
  end

  // first cut and the remap divider run side by side, six stages each
  logic           c1_v, c1_cubic;
  bcs_pkg::crv_t  c1_lo, c1_hi;
  bcs_pkg::side_t c1_side;
  logic [16:0]    r;

  bcs_cut u_cut1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .in_crv    (crv_r),
    .in_t      (t1),
    .in_cubic  (cubic_r),
    .in_side   (side1),
    .out_valid (c1_v),
    .out_lo    (c1_lo),
    .out_hi    (c1_hi),
    .out_cubic (c1_cubic),
    .out_side  (c1_side)
  );

  bcs_div u_div (
    .clk  (clk),
    .en   (en),
    .an   (an),
    .ad   (ad),
    .zero (dzero),
    .sat  (dsat),
    .r    (r)
  );

  // non-interior cases are settled here and ride along the second cut
  bcs_pkg::side_t side2;

  always_comb begin
    side2.mode = c1_side.mode;
    side2.eb   = c1_hi;
    side2.ea   = (c1_side.mode == bcs_pkg::MODE_RIGHT) ? c1_hi : c1_lo;
  end

  logic           c2_v, c2_cubic;
  bcs_pkg::crv_t  c2_lo, c2_hi;
  bcs_pkg::side_t c2_side;

  bcs_cut u_cut2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c1_v),
    .in_crv    (c1_hi),
    .in_t      ({1'b0, r}),
    .in_cubic  (c1_cubic),
    .in_side   (side2),
    .out_valid (c2_v),
    .out_lo    (c2_lo),
    .out_hi    (c2_hi),
    .out_cubic (c2_cubic),
    .out_side  (c2_side)
  );

  // output: the serializer puts the points of each item on the bus one after another
  logic [1:0]   o_pi;
  bcs_pkg::pt_t o_pt;

  bcs_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c2_v),
    .in_lo     (c2_lo),
    .in_cubic  (c2_cubic),
    .in_side   (c2_side),
    .free      (ser_free),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_half  (out_tuser),
    .out_pi    (o_pi),
    .out_pt    (o_pt),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b0, o_pt.y, o_pt.x, o_pi};

  // the upper half of the second cut is not used; it is only reduced here
  logic c2_hi_unused;
  assign c2_hi_unused = ^c2_hi;

  // a point with a left-half tag never closes an item
  a_left_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bcs_pkg::HALF_LEFT |-> !out_tlast)
    else $error("left half point marked last");

  // the points of one item follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an item's points");

  // last point sits at index two or three
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1:0] == 2'd2 || out_tdata[1:0] == 2'd3)
    else $error("last point at a low index");

  // no new item is taken while the serializer still holds unsent points
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while serializer busy");

endmodule

// ----- design/bcs_div.sv -----
`timescale 1ns / 1ps
module bcs_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bcs_pkg::DIV_W-1:0]    an,
  input  logic [bcs_pkg::DIV_W-1:0]    ad,
  input  logic                         zero,
  input  logic                         sat,
  output logic [16:0]                  r
);

  typedef struct packed {
    logic [bcs_pkg::DIV_W-1:0] rem;
    logic [bcs_pkg::Q_W-1:0]   q;
    logic [bcs_pkg::DIV_W-1:0] ad;
    logic                      zero;
    logic                      sat;
  } dstg_t;

  dstg_t       d_r   [5];
  dstg_t       d_nxt [5];
  dstg_t       fin;
  logic [16:0] r_r;
  logic [16:0] r_nxt;
  logic [19:0] rsum;
  logic [16:0] qf;

  // one restoring step: one quotient bit
  function automatic dstg_t step(input dstg_t s);
    dstg_t       o;
    logic [19:0] t2;
    o  = s;
    t2 = {s.rem, 1'b0};
    if (t2 >= {1'b0, s.ad}) begin
      t2      = t2 - {1'b0, s.ad};
      o.q     = {s.q[bcs_pkg::Q_W-2:0], 1'b1};
    end else begin
      o.q     = {s.q[bcs_pkg::Q_W-2:0], 1'b0};
    end
    o.rem = t2[bcs_pkg::DIV_W-1:0];
    return o;
  endfunction

  always_comb begin
    d_nxt[0] = step(step(step('{rem: an, q: '0, ad: ad, zero: zero, sat: sat})));
    for (int k = 1; k < 5; k++) begin
      d_nxt[k] = step(step(step(d_r[k-1])));
    end
    fin  = step(d_r[4]);
    rsum = {1'b0, fin.rem} + {2'b0, fin.ad[bcs_pkg::DIV_W-1:1]};
    qf   = {1'b0, fin.q} + 17'(rsum >= {1'b0, fin.ad});
    if (fin.zero) begin
      r_nxt = '0;
    end else if (fin.sat) begin
      r_nxt = 17'd65536;
    end else begin
      r_nxt = qf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        d_r[k] <= d_nxt[k];
      end
      r_r <= r_nxt;
    end
  end

  assign r = r_r;

endmodule

// ----- design/bcs_cut.sv -----
`timescale 1ns / 1ps
module bcs_cut (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  bcs_pkg::crv_t            in_crv,
  input  logic signed [17:0]       in_t,
  input  logic                     in_cubic,
  input  bcs_pkg::side_t           in_side,
  output logic                     out_valid,
  output bcs_pkg::crv_t            out_lo,
  output bcs_pkg::crv_t            out_hi,
  output logic                     out_cubic,
  output bcs_pkg::side_t           out_side
);

  typedef struct packed {
    bcs_pkg::crv_t      w;
    bcs_pkg::crv_t      lo;
    bcs_pkg::crv_t      hi;
    logic signed [17:0] t;
    logic               cubic;
    bcs_pkg::side_t     side;
  } cstg_t;

  // per level: a multiply stage then an add and round stage
  cstg_t ms_r  [3];
  cstg_t m_nxt [3];
  cstg_t as_r  [3];
  cstg_t a_nxt [3];
  logic [2:0] mv_r;
  logic [2:0] av_r;
  logic signed [bcs_pkg::PROD_W-1:0] prx_r [3][3];
  logic signed [bcs_pkg::PROD_W-1:0] pry_r [3][3];
  logic [1:0] hidx;

  always_comb begin
    hidx = '0;
    m_nxt[0].w     = in_crv;
    m_nxt[0].lo    = '0;
    m_nxt[0].lo[0] = in_crv[0];
    m_nxt[0].hi    = '0;
    if (in_cubic) begin
      m_nxt[0].hi[3] = in_crv[3];
    end else begin
      m_nxt[0].hi[2] = in_crv[2];
    end
    m_nxt[0].t     = in_t;
    m_nxt[0].cubic = in_cubic;
    m_nxt[0].side  = in_side;
    for (int g = 1; g < 3; g++) begin
      m_nxt[g] = as_r[g-1];
    end
    for (int g = 0; g < 3; g++) begin
      a_nxt[g] = ms_r[g];
      for (int i = 0; i < 3; i++) begin
        a_nxt[g].w[i].x = bcs_pkg::lerp_fin(ms_r[g].w[i].x, prx_r[g][i]);
        a_nxt[g].w[i].y = bcs_pkg::lerp_fin(ms_r[g].w[i].y, pry_r[g][i]);
      end
      // quadratic has no third level
      if (ms_r[g].cubic || g < 2) begin
        a_nxt[g].lo[g+1] = a_nxt[g].w[0];
        hidx = ms_r[g].cubic ? 2'(2 - g) : 2'(1 - g);
        a_nxt[g].hi[hidx] = a_nxt[g].w[hidx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        ms_r[g] <= m_nxt[g];
        as_r[g] <= a_nxt[g];
        for (int i = 0; i < 3; i++) begin
          prx_r[g][i] <= bcs_pkg::lmul(m_nxt[g].w[i].x, m_nxt[g].w[i+1].x, m_nxt[g].t);
          pry_r[g][i] <= bcs_pkg::lmul(m_nxt[g].w[i].y, m_nxt[g].w[i+1].y, m_nxt[g].t);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
      av_r <= '0;
    end else if (en) begin
      mv_r <= {av_r[1:0], in_valid};
      av_r <= mv_r;
    end
  end

  assign out_valid = av_r[2];
  assign out_lo    = as_r[2].lo;
  assign out_hi    = as_r[2].hi;
  assign out_cubic = as_r[2].cubic;
  assign out_side  = as_r[2].side;

endmodule

// ----- design/bcs_ser.sv -----
`timescale 1ns / 1ps
module bcs_ser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  bcs_pkg::crv_t   in_lo,
  input  logic            in_cubic,
  input  bcs_pkg::side_t  in_side,
  output logic            free,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [1:0]      out_half,
  output logic [1:0]      out_pi,
  output bcs_pkg::pt_t    out_pt,
  output logic            out_last
);

  bcs_pkg::crv_t  a_r, b_r;
  bcs_pkg::mode_t mode_r;
  logic           cubic_r;
  logic           v_r, v_nxt;
  logic           seg_r, seg_nxt;
  logic [1:0]     pi_r, pi_nxt;
  logic           deg_end, final_pt, load;

  assign deg_end  = pi_r == (cubic_r ? 2'd3 : 2'd2);
  assign final_pt = deg_end && (mode_r != bcs_pkg::MODE_SPLIT || seg_r);
  assign free     = !v_r || (out_ready && final_pt);
  assign load     = free && in_valid;

  always_comb begin
    v_nxt   = v_r;
    seg_nxt = seg_r;
    pi_nxt  = pi_r;
    if (load) begin
      v_nxt   = 1'b1;
      seg_nxt = 1'b0;
      pi_nxt  = '0;
    end else if (v_r && out_ready) begin
      if (final_pt) begin
        v_nxt = 1'b0;
      end else if (deg_end) begin
        seg_nxt = 1'b1;
        pi_nxt  = '0;
      end else begin
        pi_nxt = pi_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      seg_r <= 1'b0;
      pi_r  <= '0;
    end else begin
      v_r   <= v_nxt;
      seg_r <= seg_nxt;
      pi_r  <= pi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r     <= (in_side.mode == bcs_pkg::MODE_MID) ? in_lo : in_side.ea;
      b_r     <= in_side.eb;
      mode_r  <= in_side.mode;
      cubic_r <= in_cubic;
    end
  end

  assign out_valid = v_r;
  assign out_pi    = pi_r;
  assign out_pt    = seg_r ? b_r[pi_r] : a_r[pi_r];
  assign out_last  = final_pt;
  assign out_half  = (mode_r != bcs_pkg::MODE_SPLIT) ? bcs_pkg::HALF_SEG :
                     (seg_r ? bcs_pkg::HALF_RIGHT : bcs_pkg::HALF_LEFT);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } fpt_t;

  typedef struct {
    logic [1:0]  half;
    logic [1:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } ctl_pt_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [295:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  ctl_pt_t expected_pts[$];
  int  n_errors;
  int  n_items;
  int  n_points;
  bit  idle_on;
  bit  hold_off;

  bezier_curve_split dut (.*);

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // signed 32 bit saturation
  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // a + floor(((b-a)*t + 2^15) / 2^16), arithmetic shift gives the floor
  function automatic logic signed [63:0] interp(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic signed [63:0] t);
    logic signed [63:0] p;
    p = (b - a) * t + 64'sd32768;
    return sat32(a + (p >>> 16));
  endfunction

  // one de casteljau pass, n is the degree
  task automatic casteljau(input fpt_t p[4], input int n, input logic signed [63:0] t,
                           output fpt_t lo[4], output fpt_t hi[4]);
    fpt_t w[4];
    w = p;
    lo = p;
    hi = p;
    lo[0] = w[0];
    hi[n] = w[n];
    for (int lvl = 1; lvl <= n; lvl++) begin
      for (int i = 0; i <= n - lvl; i++) begin
        w[i].x = interp(w[i].x, w[i+1].x, t);
        w[i].y = interp(w[i].y, w[i+1].y, t);
      end
      lo[lvl] = w[0];
      hi[n-lvl] = w[n-lvl];
    end
  endtask

  // (te - ts) / (1 - ts) rounded, clamped to [0, 1]
  function automatic logic signed [63:0] remap_t(input logic signed [63:0] ts,
                                                 input logic signed [63:0] te);
    logic signed [63:0] num, den, an, ad, q;
    num = te - ts;
    den = 64'sd65536 - ts;
    if (den == 0 || num == 0) return 0;
    if ((num < 0) != (den < 0)) return 0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (an * 65536 + ad / 2) / ad;
    return q > 65536 ? 64'sd65536 : q;
  endfunction

  task automatic queue_curve(input fpt_t c[4], input int n, input logic [1:0] half,
                             input bit fin);
    ctl_pt_t e;
    for (int i = 0; i <= n; i++) begin
      e.half = half;
      e.idx  = 2'(i);
      e.x    = c[i].x[31:0];
      e.y    = c[i].y[31:0];
      e.last = fin && (i == n);
      expected_pts = {expected_pts, e};
    end
  endtask

  // works out the control points one curve produces
  task automatic predict_split(input logic op, input logic [1:0] deg,
                               input logic [31:0] coord[8],
                               input logic [17:0] ts_raw, input logic [17:0] te_raw);
    fpt_t p[4], lo[4], hi[4], lo2[4], hi2[4];
    int n;
    logic signed [63:0] ts, te;
    n  = (deg == 2'd3) ? 3 : 2;
    ts = 64'($signed(ts_raw));
    te = 64'($signed(te_raw));
    for (int i = 0; i < 4; i++) begin
      p[i].x = 64'($signed(coord[2*i]));
      p[i].y = 64'($signed(coord[2*i+1]));
    end
    if (!op) begin
      casteljau(p, n, ts, lo, hi);
      queue_curve(lo, n, bcs_pkg::HALF_LEFT, 1'b0);
      queue_curve(hi, n, bcs_pkg::HALF_RIGHT, 1'b1);
    end else if (ts <= 0) begin
      casteljau(p, n, te, lo, hi);
      queue_curve(lo, n, bcs_pkg::HALF_SEG, 1'b1);
    end else if (te >= 65536) begin
      casteljau(p, n, ts, lo, hi);
      queue_curve(hi, n, bcs_pkg::HALF_SEG, 1'b1);
    end else begin
      casteljau(p, n, ts, lo, hi);
      casteljau(hi, n, remap_t(ts, te), lo2, hi2);
      queue_curve(lo2, n, bcs_pkg::HALF_SEG, 1'b1);
    end
  endtask

  // random idle burst on the input while idle_on is set
  task automatic maybe_idle();
    if (idle_on && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
  endtask

  // send one curve and wait for its acceptance
  task automatic send_curve(input logic op, input logic [1:0] deg,
                            input logic [31:0] coord[8],
                            input logic [17:0] ts, input logic [17:0] te);
    logic [295:0] d;
    maybe_idle();
    d = '0;
    d[1:0] = deg;
    for (int i = 0; i < 8; i++) d[2 + 32*i +: 32] = coord[i];
    d[258 +: 18] = ts;
    d[276 +: 18] = te;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_split(op, deg, coord, ts, te);
    n_items++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(65536 * 4) - 32'd131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [17:0] rand_t();
    case ($urandom_range(7))
      0: return 18'd0;
      1: return 18'd65536;
      2: return 18'($urandom);
      3: return 18'h20000;
      default: return 18'($urandom_range(65536));
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [31:0] c[8];
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 8; i++) c[i] = rand_coord();
      send_curve(1'($urandom_range(1)), 2'($urandom), c, rand_t(), rand_t());
    end
  endtask

  // extremes of every field, both opcodes, each extraction case
  task automatic test_directed();
    logic [31:0] c[8];
    logic [31:0] mx[8];
    logic [31:0] mn[8];
    foreach (c[i]) c[i] = 32'(i * 32'h00030000 - 32'h00050000);
    foreach (mx[i]) mx[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
    foreach (mn[i]) mn[i] = (i % 3) ? 32'h7fffffff : 32'h80000000;
    send_curve(1'b0, 2'd2, c, 18'd32768, 18'd0);
    send_curve(1'b0, 2'd3, c, 18'd16384, 18'd0);
    send_curve(1'b0, 2'd3, mx, 18'h1ffff, 18'h3ffff);
    send_curve(1'b0, 2'd2, mn, 18'h20000, 18'h1ffff);
    send_curve(1'b0, 2'd0, c, 18'd0, 18'd0);
    send_curve(1'b0, 2'd1, mx, 18'd65536, 18'd0);
    // start at or below zero
    send_curve(1'b1, 2'd3, c, 18'd0, 18'd40000);
    send_curve(1'b1, 2'd2, mx, 18'h3ffff, 18'h1ffff);
    // end at or above one
    send_curve(1'b1, 2'd3, c, 18'd20000, 18'd65536);
    send_curve(1'b1, 2'd2, mn, 18'd100, 18'h1ffff);
    // interior, including a reversed and an empty range
    send_curve(1'b1, 2'd3, c, 18'd16384, 18'd49152);
    send_curve(1'b1, 2'd3, mx, 18'd49152, 18'd16384);
    send_curve(1'b1, 2'd2, c, 18'd30000, 18'd30000);
    // zero denominator: t_start is exactly one, end stays below one; then t_start above one, saturating remap
    send_curve(1'b1, 2'd3, c, 18'd65536, 18'd1000);
    send_curve(1'b1, 2'd3, mn, 18'd70000, 18'd60000);
    send_curve(1'b1, 2'd2, mx, 18'd90000, 18'h30000);
  endtask

  // receiver holds off while the sender keeps offering curves
  task automatic test_backpressure();
    hold_off = 1'b1;
    send_random(30);
    hold_off = 1'b0;
  endtask

  task automatic test_random();
    send_random(420);
    idle_on = 1'b0;
    send_random(40);
  endtask

  // receiver: random stalls, plus a long counted hold-off
  initial begin
    int held;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        held = 0;
        out_tready <= 1'b0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        out_tready <= 1'b1;
        while (hold_off) @(posedge clk);
      end else if (idle_on && $urandom_range(5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ctl_pt_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_points++;
      if (expected_pts.size() == 0) begin
        $error("unexpected point half=%0d x=%h", out_tuser, out_tdata[33:2]);
        n_errors++;
      end else begin
        e = expected_pts.pop_front();
        if (out_tuser !== e.half) begin
          $error("half: expected %0d actual %0d", e.half, out_tuser);
          n_errors++;
        end
        if (out_tdata[1:0] !== e.idx) begin
          $error("point_index: expected %0d actual %0d", e.idx, out_tdata[1:0]);
          n_errors++;
        end
        if (out_tdata[33:2] !== e.x) begin
          $error("out_x: expected %h actual %h", e.x, out_tdata[33:2]);
          n_errors++;
        end
        if (out_tdata[65:34] !== e.y) begin
          $error("out_y: expected %h actual %h", e.y, out_tdata[65:34]);
          n_errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    n_errors  = 0;
    n_items   = 0;
    n_points  = 0;
    idle_on   = 1'b1;
    hold_off  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    waited = 0;
    while (expected_pts.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (expected_pts.size() != 0) begin
      $error("%0d points never arrived", expected_pts.size());
      n_errors++;
    end
    $display("%0d curves split, %0d control points checked", n_items, n_points);
    $display("covered both opcodes, both degrees, all extraction cases, long output stall");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
